FILE: hdl/assert_macros.svh
// Assertion macros for the page table walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTW_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define PTW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define PTW_ASSERT_SAME(lbl, pre, post, msg)
`define PTW_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: hdl/ptw_pkg.sv
// Types and constants shared by the page table walker modules.
package ptw_pkg;

  localparam int unsigned PTW_TABLE_COUNT    = 16;
  localparam int unsigned PTW_ENTRIES        = 512;
  localparam int unsigned PTW_IDX_W          = 9;
  localparam int unsigned PTW_PHYS_ADDR_BITS = 40;
  localparam int unsigned PTW_OUT_PA_W       = 40;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_XLATE  = 2'd1;
  localparam logic [1:0] REQ_UNMAP  = 2'd2;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_NOT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_OUT_OF_STORE = 2'd2;

  localparam logic [1:0] SIZE_NONE = 2'd0;

  localparam logic [1:0] LVL_PT   = 2'd0;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PML4 = 2'd3;

  localparam logic [63:0] OFF_4K = 64'h0000_0000_0000_0fff;
  localparam logic [63:0] OFF_2M = 64'h0000_0000_001f_ffff;
  localparam logic [63:0] OFF_1G = 64'h0000_0000_3fff_ffff;

  localparam int unsigned BIT_P   = 0;
  localparam int unsigned BIT_RW  = 1;
  localparam int unsigned BIT_US  = 2;
  localparam int unsigned BIT_PCD = 4;
  localparam int unsigned BIT_PS  = 7;
  localparam int unsigned BIT_XD  = 63;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } ptw_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] virt_addr;
    logic [12:0] entry_location;
    logic [63:0] entry_value;
  } ptw_req_t;

  typedef struct packed {
    logic [PTW_OUT_PA_W-1:0] phys_addr;
    logic [1:0]              page_size_code;
    logic [3:0]              permissions;
    logic [1:0]              status;
  } ptw_rsp_t;

endpackage

FILE: hdl/ptw_store.sv
// Synchronous page table store with one write port and one registered read port.
module ptw_store
  import ptw_pkg::*;
#(
  parameter int unsigned DEPTH  = PTW_TABLE_COUNT * PTW_ENTRIES,
  parameter int unsigned ADDR_W = $clog2(PTW_TABLE_COUNT * PTW_ENTRIES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [63:0]       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [63:0]       rd_data
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/ptw_ctrl.sv
// Walk sequencer: store clearing, request decode, level-by-level walk and result register.
module ptw_ctrl
  import ptw_pkg::*;
#(
  parameter int unsigned TABLE_COUNT    = PTW_TABLE_COUNT,
  parameter int unsigned PHYS_ADDR_BITS = PTW_PHYS_ADDR_BITS,
  parameter int unsigned TBL_W          = $clog2(TABLE_COUNT),
  parameter int unsigned ADDR_W         = TBL_W + PTW_IDX_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ptw_req_t          req,
  input  logic [3:0]        root_table,
  output logic              busy,
  output logic              out_valid,
  output ptw_rsp_t          out_rsp,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_wr_addr,
  output logic [63:0]       mem_wr_data,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_rd_addr,
  input  logic [63:0]       mem_rd_data
);

  localparam int unsigned DEPTH = TABLE_COUNT * PTW_ENTRIES;
  localparam logic [63:0] PA_MASK = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  function automatic logic [PTW_IDX_W-1:0] idx_of(input logic [47:0] va,
                                                  input logic [1:0] lvl);
    case (lvl)
      LVL_PML4: idx_of = va[47:39];
      LVL_PDPT: idx_of = va[38:30];
      LVL_PD:   idx_of = va[29:21];
      default:  idx_of = va[20:12];
    endcase
  endfunction

  function automatic logic [63:0] off_of(input logic [1:0] lvl);
    case (lvl)
      LVL_PT:  off_of = OFF_4K;
      LVL_PD:  off_of = OFF_2M;
      default: off_of = OFF_1G;
    endcase
  endfunction

  ptw_state_t state_r, state_nxt;
  logic [1:0]        lvl_r, lvl_nxt;
  logic              user_r, user_nxt;
  logic              unmap_r, unmap_nxt;
  logic [47:0]       va_r, va_nxt;
  logic [ADDR_W-1:0] slot_r, slot_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  ptw_rsp_t          out_rsp_r, out_rsp_nxt;

  logic [63:0]                  entry;
  logic                         is_leaf;
  logic                         leaf_user;
  logic [PHYS_ADDR_BITS-13:0]   ptr;
  logic                         ptr_out;
  logic [63:0]                  off;
  logic [63:0]                  pa64;
  logic                         root_out;
  logic                         loc_in_range;

  assign entry        = mem_rd_data;
  assign is_leaf      = (lvl_r == LVL_PT) || ((lvl_r != LVL_PML4) && entry[BIT_PS]);
  assign leaf_user    = user_r & entry[BIT_US];
  assign ptr          = entry[PHYS_ADDR_BITS-1:12];
  assign ptr_out      = 64'(ptr) >= 64'(TABLE_COUNT);
  assign off          = off_of(lvl_r);
  assign pa64         = (entry & PA_MASK & ~off) | ({16'h0, va_r} & off);
  assign root_out     = 32'(root_table) >= 32'(TABLE_COUNT);
  assign loc_in_range = 32'(req.entry_location) < 32'(DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r     <= lvl_nxt;
    user_r    <= user_nxt;
    unmap_r   <= unmap_nxt;
    va_r      <= va_nxt;
    slot_r    <= slot_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    user_nxt      = user_r;
    unmap_nxt     = unmap_r;
    va_nxt        = va_r;
    slot_nxt      = slot_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = '0;
    mem_we        = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;
    mem_re        = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wr_addr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (req.req_type) inside
            REQ_XLATE, REQ_UNMAP: begin
              if (root_out) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = STAT_OUT_OF_STORE;
              end else begin
                mem_re    = 1'b1;
                slot_nxt  = {TBL_W'(root_table), req.virt_addr[47:39]};
                va_nxt    = req.virt_addr;
                lvl_nxt   = LVL_PML4;
                user_nxt  = 1'b1;
                unmap_nxt = (req.req_type == REQ_UNMAP);
                state_nxt = ST_WALK;
              end
            end
            REQ_WRITE: begin
              mem_we        = loc_in_range;
              mem_wr_addr   = ADDR_W'(req.entry_location);
              mem_wr_data   = req.entry_value;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (!entry[BIT_P]) begin
          out_valid_nxt      = 1'b1;
          out_rsp_nxt.status = STAT_NOT_PRESENT;
          state_nxt          = ST_IDLE;
        end else if (is_leaf) begin
          out_valid_nxt              = 1'b1;
          out_rsp_nxt.status         = STAT_OK;
          out_rsp_nxt.page_size_code = lvl_r + 2'd1;
          state_nxt                  = ST_IDLE;
          if (unmap_r) begin
            mem_we      = 1'b1;
            mem_wr_addr = slot_r;
            mem_wr_data = entry & ~64'h1;
          end else begin
            out_rsp_nxt.phys_addr   = pa64[PTW_OUT_PA_W-1:0];
            out_rsp_nxt.permissions = {entry[BIT_PCD], entry[BIT_XD], leaf_user,
                                       entry[BIT_RW]};
          end
        end else if (ptr_out) begin
          out_valid_nxt      = 1'b1;
          out_rsp_nxt.status = STAT_OUT_OF_STORE;
          state_nxt          = ST_IDLE;
        end else begin
          mem_re   = 1'b1;
          slot_nxt = {TBL_W'(ptr), idx_of(va_r, lvl_r - 2'd1)};
          lvl_nxt  = lvl_r - 2'd1;
          user_nxt = leaf_user;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign mem_rd_addr = slot_nxt;
  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_rsp     = out_rsp_r;

endmodule

FILE: hdl/four_level_page_table_walker_core.sv
// Top level of the four-level page table walker with its table store.
//
// Requests are taken on start while busy is low: write a table entry, translate a
// 48-bit virtual address, or unmap it. Every request gives exactly one result, shown
// on out_rsp for one cycle with out_valid high; the receiver cannot hold results off.
// A write, an unused request code, or a root table outside the store gives its result
// in the cycle after acceptance and the next request may follow in that cycle.
// A translate or unmap reads one entry per level, one to four levels, from the
// synchronous store through its single registered read port.
// An unmap clears the present bit of the leaf in the last walk cycle.
// cfg_root_table loads the root table number when cfg_valid is high; cfg_ready is
// always high, and writes are expected only while no request is in flight.
// After reset the store is cleared one entry per cycle, all TABLE_COUNT * 512 entries
// (8192 by default), with busy high; root_table resets to zero.
module four_level_page_table_walker_core
  import ptw_pkg::*;
#(
  parameter int unsigned TABLE_COUNT    = PTW_TABLE_COUNT,
  parameter int unsigned PHYS_ADDR_BITS = PTW_PHYS_ADDR_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ptw_req_t in_req,
  output logic     out_valid,
  output ptw_rsp_t out_rsp,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [3:0] cfg_root_table
);

  `include "assert_macros.svh"

  localparam int unsigned TBL_W  = $clog2(TABLE_COUNT);
  localparam int unsigned ADDR_W = TBL_W + PTW_IDX_W;
  localparam int unsigned DEPTH  = TABLE_COUNT * PTW_ENTRIES;

  logic [3:0]        root_table_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [63:0]       mem_wr_data;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [63:0]       mem_rd_data;
  logic              rsp_fault;
  logic              rsp_body_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_table_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_table_r <= cfg_root_table;
    end
  end

  ptw_ctrl #(
    .TABLE_COUNT   (TABLE_COUNT),
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS),
    .TBL_W         (TBL_W),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req        (in_req),
    .root_table (root_table_r),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp),
    .mem_we     (mem_we),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_re     (mem_re),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  ptw_store #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_re),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign rsp_fault     = (out_rsp.status != STAT_OK);
  assign rsp_body_zero = (out_rsp.phys_addr == '0) && (out_rsp.page_size_code == SIZE_NONE) &&
                         (out_rsp.permissions == '0);

  `PTW_ASSERT_NEXT(a_accept_progress, start && !busy, out_valid || busy, "request lost")
  `PTW_ASSERT_SAME(a_result_idle, out_valid, !busy, "result shown while busy")
  `PTW_ASSERT_SAME(a_fault_zero, out_valid && rsp_fault, rsp_body_zero, "fault result not zero")

endmodule

FILE: dv/tb_four_level_page_table_walker_core.sv
// Self-checking testbench for the four-level page table walker core.
`timescale 1ns / 100ps

module tb_four_level_page_table_walker_core;
  import ptw_pkg::*;

  localparam int unsigned STORE_DEPTH = PTW_TABLE_COUNT * PTW_ENTRIES;
  localparam logic [63:0] PA_MASK     = (64'd1 << PTW_PHYS_ADDR_BITS) - 64'd1;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [1:0]  SIZE_4K     = 2'd1;
  localparam logic [1:0]  SIZE_2M     = 2'd2;
  localparam logic [1:0]  SIZE_1G     = 2'd3;
  localparam int unsigned PHASE_REQUESTS = 330;

  class translation_scoreboard;
    logic [63:0] tables [STORE_DEPTH];
    logic [3:0]  root;
    ptw_rsp_t    pending_results [$];
    int unsigned mismatches;

    function new();
      foreach (tables[i]) tables[i] = '0;
      root = '0;
      mismatches = 0;
    endfunction

    function ptw_rsp_t walk_tables(input logic [47:0] va, output int unsigned leaf);
      ptw_rsp_t    r;
      logic [63:0] tbl, e, off, pa;
      logic        user;
      int unsigned sh, slot;
      r = '0;
      leaf = 0;
      tbl = 64'(root);
      user = 1'b1;
      for (int lvl = 4; lvl >= 1; lvl--) begin
        sh = 12 + 9 * (lvl - 1);
        if (tbl >= PTW_TABLE_COUNT) begin
          r.status = STAT_OUT_OF_STORE;
          return r;
        end
        slot = 32'(tbl) * PTW_ENTRIES + 32'((64'(va) >> sh) & 64'h1ff);
        e = tables[slot];
        if (!e[BIT_P]) begin
          r.status = STAT_NOT_PRESENT;
          return r;
        end
        if (!e[BIT_US]) user = 1'b0;
        if (lvl == 1 || (lvl < 4 && e[BIT_PS])) begin
          off = (64'd1 << sh) - 64'd1;
          pa = (e & PA_MASK & ~off) | (64'(va) & off);
          r.phys_addr = pa[PTW_OUT_PA_W-1:0];
          r.page_size_code = (lvl == 1) ? SIZE_4K : (lvl == 2) ? SIZE_2M : SIZE_1G;
          r.permissions = {e[BIT_PCD], e[BIT_XD], user, e[BIT_RW]};
          leaf = slot;
          return r;
        end
        tbl = (e & PA_MASK) >> 12;
      end
      r.status = STAT_NOT_PRESENT;
      return r;
    endfunction

    function void note_request(input ptw_req_t req);
      ptw_rsp_t    res, found;
      int unsigned leaf;
      res = '0;
      case (req.req_type)
        REQ_WRITE: begin
          if (req.entry_location < STORE_DEPTH) tables[req.entry_location] = req.entry_value;
        end
        REQ_XLATE: begin
          res = walk_tables(req.virt_addr, leaf);
        end
        REQ_UNMAP: begin
          found = walk_tables(req.virt_addr, leaf);
          if (found.status == STAT_OK) tables[leaf][BIT_P] = 1'b0;
          res.page_size_code = found.page_size_code;
          res.status = found.status;
        end
        default: begin
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void report(input string what, input ptw_rsp_t want, input ptw_rsp_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: expected pa=%h size=%0d perm=%h status=%0d", $time, what,
                 want.phys_addr, want.page_size_code, want.permissions, want.status);
        $display("%0t: %s: actual   pa=%h size=%0d perm=%h status=%0d", $time, what,
                 got.phys_addr, got.page_size_code, got.permissions, got.status);
      end
    endfunction

    function void check_result(input ptw_rsp_t got);
      ptw_rsp_t want;
      if (pending_results.size() == 0) begin
        report("result with no request waiting", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.phys_addr !== want.phys_addr ||
          got.page_size_code !== want.page_size_code ||
          got.permissions !== want.permissions ||
          got.status !== want.status) begin
        report("result mismatch", want, got);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  ptw_req_t   in_req = '0;
  logic       out_valid;
  ptw_rsp_t   out_rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_root_table = '0;

  translation_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned requests_sent = 0;
  logic [47:0] mapped_q [$];

  four_level_page_table_walker_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_rsp       (out_rsp),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_root_table(cfg_root_table)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_rsp);
  end

  function automatic logic [47:0] rand_va();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [63:0] rand_entry();
    return {$urandom, $urandom};
  endfunction

  task automatic send(input ptw_req_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_req <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(req);
    if (req.req_type != REQ_UNUSED) requests_sent++;
  endtask

  task automatic send_write(input logic [12:0] loc, input logic [63:0] value);
    ptw_req_t req;
    req.req_type = REQ_WRITE;
    req.virt_addr = rand_va();
    req.entry_location = loc;
    req.entry_value = value;
    send(req);
  endtask

  task automatic send_walk(input logic [1:0] kind, input logic [47:0] va);
    ptw_req_t req;
    req.req_type = kind;
    req.virt_addr = va;
    req.entry_location = 13'($urandom);
    req.entry_value = rand_entry();
    send(req);
  endtask

  task automatic send_unused();
    logic [127:0] raw;
    ptw_req_t     req;
    raw = {$urandom, $urandom, $urandom, $urandom};
    req = raw[126:0];
    req.req_type = REQ_UNUSED;
    send(req);
  endtask

  task automatic load_root(input logic [3:0] value);
    start <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_root_table <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.root = value;
  endtask

  // Writes one entry per level along the path of va, ending in a leaf of random size.
  // A broken path has one entry not present or one pointer outside the store.
  task automatic build_path(input logic [47:0] va, input bit broken);
    int          leaf_lvl, bad_lvl, sh, pick;
    logic [3:0]  tbl, nxt;
    logic [63:0] e;
    pick = $urandom_range(0, 3);
    leaf_lvl = (pick < 2) ? 1 : (pick == 2) ? 2 : 3;
    bad_lvl = broken ? $urandom_range(leaf_lvl, 4) : 0;
    tbl = sb.root;
    for (int lvl = 4; lvl >= leaf_lvl; lvl--) begin
      sh = 12 + 9 * (lvl - 1);
      nxt = 4'($urandom);
      e = rand_entry();
      e[BIT_P] = 1'b1;
      e[BIT_US] = ($urandom_range(0, 7) != 0);
      if (lvl == leaf_lvl) begin
        if (lvl != 1) e[BIT_PS] = 1'b1;
      end else begin
        e[39:12] = {24'd0, nxt};
        if (lvl != 4) e[BIT_PS] = 1'b0;
      end
      if (lvl == bad_lvl) begin
        if (lvl != leaf_lvl && $urandom_range(0, 1) == 1)
          e[39:12] = 28'($urandom_range(16, 28'hfffffff));
        else
          e[BIT_P] = 1'b0;
      end
      send_write({tbl, 9'((va >> sh) & 48'h1ff)}, e);
      tbl = nxt;
    end
  endtask

  task automatic probe_address(input logic [47:0] va);
    int unsigned n;
    logic [47:0] v;
    n = $urandom_range(1, 4);
    repeat (n) begin
      v = va;
      v[11:0] = 12'($urandom);
      if ($urandom_range(0, 3) == 0) v[29:12] = 18'($urandom);
      send_walk(($urandom_range(0, 3) == 0) ? REQ_UNMAP : REQ_XLATE, v);
    end
  endtask

  task automatic run_phase(input int unsigned goal);
    int unsigned pick;
    logic [47:0] va;
    goal = requests_sent + goal;
    while (requests_sent < goal) begin
      pick = $urandom_range(0, 99);
      va = rand_va();
      if (pick < 55) begin
        build_path(va, 1'b0);
        probe_address(va);
        mapped_q.push_back(va);
        if (mapped_q.size() > 32) void'(mapped_q.pop_front());
      end else if (pick < 65) begin
        build_path(va, 1'b1);
        probe_address(va);
      end else if (pick < 80 && mapped_q.size() != 0) begin
        probe_address(mapped_q[$urandom_range(0, mapped_q.size() - 1)]);
      end else if (pick < 88) begin
        send_walk(($urandom_range(0, 1) == 1) ? REQ_UNMAP : REQ_XLATE, va);
      end else if (pick < 95) begin
        send_write(13'($urandom), rand_entry());
      end else begin
        send_unused();
      end
    end
  endtask

  initial begin
    ptw_req_t    req;
    logic [47:0] va_top;
    va_top = '1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    load_root(4'd0);

    send_walk(REQ_XLATE, 48'd0);
    send_write({4'd0, 9'h1ff}, 64'h0000_0000_0001_0001);
    send_walk(REQ_XLATE, va_top);
    send_write({4'd0, 9'h1ff}, 64'hffff_ff00_0000_1097);
    send_write({4'd1, 9'h1ff}, 64'h0000_0000_0000_2007);
    send_write({4'd2, 9'h1ff}, 64'h0000_0000_0000_3007);
    send_write({4'd3, 9'h1ff}, 64'hffff_ffff_ffff_ffff);
    send_walk(REQ_XLATE, va_top);
    send_walk(REQ_XLATE, 48'hffff_ffff_f000);
    send_write({4'd2, 9'h1ff}, 64'h0000_00ab_cde0_0083);
    send_walk(REQ_XLATE, va_top);
    send_write({4'd1, 9'h1ff}, 64'h8000_0012_c000_0095);
    send_walk(REQ_XLATE, va_top);
    send_walk(REQ_UNMAP, va_top);
    send_walk(REQ_XLATE, va_top);
    send_walk(REQ_UNMAP, va_top);
    send_write({4'd1, 9'h1ff}, 64'h0000_0000_00fa_0001);
    send_walk(REQ_XLATE, va_top);
    req = '1;
    send(req);
    send_write(13'h1fff, 64'hffff_ffff_ffff_ffff);
    send_write(13'h0000, 64'h0);
    send_walk(REQ_XLATE, 48'd0);
    req = '0;
    req.req_type = REQ_UNUSED;
    send(req);

    run_phase(PHASE_REQUESTS);
    load_root(4'd15);
    run_phase(PHASE_REQUESTS);
    load_root(4'($urandom_range(1, 14)));
    run_phase(PHASE_REQUESTS);
    load_root(4'd0);
    run_phase(PHASE_REQUESTS);
    load_root(4'($urandom_range(1, 14)));
    run_phase(PHASE_REQUESTS);

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
